// File: sv/mf3_pkg.sv
// Shared types and constants of the 3x3 median filter block.
package mf3_pkg;

    // Field widths fixed by the stream formats
    localparam int PIXEL_IN_W = 16;
    localparam int POS_W      = 10;
    localparam int VALUE_W    = 16;

    // Configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam int RST_IMAGE_WIDTH  = 640;
    localparam int RST_IMAGE_HEIGHT = 480;
    localparam int MIN_DIM          = 3;

    // Results released per input transfer; a larger burst is split here
    localparam int MAX_BURST = 6;

    // Depth of the burst descriptor queue
    localparam int QDEPTH = 8;

    typedef struct packed {
        logic [PIXEL_IN_W-1:0] pixel_in;
    } pixel_item_t;

    typedef struct packed {
        logic [POS_W-1:0]   out_row;
        logic [POS_W-1:0]   out_col;
        logic [VALUE_W-1:0] out_value;
        logic               last_of_burst;
    } result_item_t;

endpackage

// File: sv/mf3_stream_if.sv
// Valid/ready stream channel with a typed payload.
interface mf3_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/mf3_median.sv
// Two-stage median of a 3x3 window: sort rows, then combine row extremes.
module mf3_median #(
    parameter int W = 16
) (
    input  logic               clk,
    input  logic [8:0][W-1:0]  window,
    output logic [W-1:0]       median
);

    logic [2:0][W-1:0] lo_reg, lo_next;
    logic [2:0][W-1:0] mi_reg, mi_next;
    logic [2:0][W-1:0] hi_reg, hi_next;
    logic [W-1:0]      median_reg, median_next;

    function automatic logic [W-1:0] min2(input logic [W-1:0] a, input logic [W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [W-1:0] max2(input logic [W-1:0] a, input logic [W-1:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [W-1:0] med3(input logic [W-1:0] a, input logic [W-1:0] b,
                                          input logic [W-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // Sort each row of the window
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            lo_next[r] = min2(min2(window[3*r], window[3*r+1]), window[3*r+2]);
            mi_next[r] = med3(window[3*r], window[3*r+1], window[3*r+2]);
            hi_next[r] = max2(max2(window[3*r], window[3*r+1]), window[3*r+2]);
        end
    end

    // Median of nine = median of (largest low, middle mid, smallest high)
    assign median_next = med3(max2(max2(lo_reg[0], lo_reg[1]), lo_reg[2]),
                              med3(mi_reg[0], mi_reg[1], mi_reg[2]),
                              min2(min2(hi_reg[0], hi_reg[1]), hi_reg[2]));

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        mi_reg     <= mi_next;
        hi_reg     <= hi_next;
        median_reg <= median_next;
    end

    assign median = median_reg;

endmodule

// File: sv/median_filter_3x3_replicated_border.sv
// Top level of the streaming 3x3 median filter with replicated border.
//
// Usage:
//   pixels  - sink channel, one grayscale sample per transfer, raster order.
//             The frame position is tracked inside; write image_width and
//             image_height first (reset values 640 x 480, clamped to 3..MAX).
//   results - source channel, one filtered pixel per transfer, tagged with
//             its row and column. Each interior pixel comes out together with
//             the border pixels that copy it, in raster order of position;
//             last_of_burst marks the final result caused by one input.
//             A 3x3 frame gives nine results from its last pixel: six are
//             released at once, the other three after the next pixel transfer.
//   cfg     - write port; any register write restarts the frame.
// Timing: one pixel per cycle sustained while the queue has room. The first
//   result of a window passes the window register, both median stages, the
//   queue and the output register. The line stores are one dual-use RAM read
//   every cycle at the next column, so no read wait is seen by the input.
// Stall: up to 8 window results wait in a descriptor queue; ready drops when
//   the queue plus the three median stages in flight would overflow it.
// Reset: counters, window, queue and output register clear at once; the line
//   RAM needs no clearing since every entry is written before a window that
//   uses it is complete.
module median_filter_3x3_replicated_border #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mf3_pkg::CFG_W-1:0]       cfg_data,
    mf3_stream_if.sink                      pixels,
    mf3_stream_if.source                    results
);
    import mf3_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int DW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = QAW + 1;
    localparam int P   = PIXEL_BITS;

    // Position codes inside one burst (row and column of the 3x3 copy grid)
    localparam logic [1:0] SUB_LOW  = 2'd0;
    localparam logic [1:0] SUB_MID  = 2'd1;
    localparam logic [1:0] SUB_HIGH = 2'd2;

    function automatic int clamp_dim(input int v, input int hi);
        int res;
        res = v;
        if (v < MIN_DIM)
            res = MIN_DIM;
        else if (v > hi)
            res = hi;
        return res;
    endfunction

    localparam logic [DW-1:0] W_RST = DW'(clamp_dim(RST_IMAGE_WIDTH, MAX_WIDTH));
    localparam logic [HW-1:0] H_RST = HW'(clamp_dim(RST_IMAGE_HEIGHT, MAX_HEIGHT));

    typedef struct packed {
        logic [RW-1:0] ci;
        logic [CW-1:0] cj;
        logic          top;
        logic          bottom;
        logic          left;
        logic          right;
    } desc_t;

    typedef struct packed {
        desc_t        d;
        logic [P-1:0] value;
    } entry_t;

    // ------------------------------------------------------------------
    // Configuration: keep the clamped dimensions only
    // ------------------------------------------------------------------
    logic [DW-1:0] w_reg;
    logic [HW-1:0] h_reg;
    logic          cfg_restart;
    logic [CW-1:0] w_lastc;
    logic [RW-1:0] h_lastc;

    assign cfg_restart = cfg_write &&
                         (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= W_RST;
            h_reg <= H_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  w_reg <= DW'(clamp_dim(int'(cfg_data), MAX_WIDTH));
                REG_IMAGE_HEIGHT: h_reg <= HW'(clamp_dim(int'(cfg_data), MAX_HEIGHT));
                default: ;
            endcase
        end
    end

    assign w_lastc = CW'(w_reg - DW'(1));
    assign h_lastc = RW'(h_reg - HW'(1));

    // ------------------------------------------------------------------
    // Input stage: frame counters, line RAM, window shift
    // ------------------------------------------------------------------
    logic              accept;
    logic [P-1:0]      pix;
    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic              col_end;
    logic              row_end;

    logic [2*P-1:0]    line_mem [MAX_WIDTH];
    logic [2*P-1:0]    rd_reg;
    logic [P-1:0]      rd_a;
    logic [P-1:0]      rd_b;

    logic [8:0][P-1:0] window_reg, window_next;

    logic              src;
    logic              src_is9;
    desc_t             desc_in;

    assign accept  = pixels.valid && pixels.ready;
    assign pix     = pixels.data.pixel_in[P-1:0];
    assign col_end = (col_reg == w_lastc);
    assign row_end = (row_reg == h_lastc);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Each RAM word holds {row before previous, previous row} at one column.
    // Read ahead at the column the next pixel will take.
    always_ff @(posedge clk)
    begin
        if (accept)
            line_mem[col_reg] <= {rd_a, pix};
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= line_mem[col_next];
    end

    assign rd_a = rd_reg[P-1:0];
    assign rd_b = rd_reg[2*P-1:P];

    always_comb
    begin
        window_next = window_reg;
        if (accept)
        begin
            for (int t = 0; t < 3; t++)
            begin
                window_next[3*t]   = window_reg[3*t+1];
                window_next[3*t+1] = window_reg[3*t+2];
            end
            window_next[2] = rd_b;
            window_next[5] = rd_a;
            window_next[8] = pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= '0;
        else
            window_reg <= window_next;
    end

    // A full window centered on (row-1, col-1) and its border copies
    assign src            = (row_reg >= RW'(2)) && (col_reg >= CW'(2));
    assign desc_in.ci     = row_reg - RW'(1);
    assign desc_in.cj     = col_reg - CW'(1);
    assign desc_in.top    = (row_reg == RW'(2));
    assign desc_in.bottom = row_end;
    assign desc_in.left   = (col_reg == CW'(2));
    assign desc_in.right  = col_end;
    assign src_is9        = src && desc_in.top && desc_in.bottom &&
                            desc_in.left && desc_in.right;

    // ------------------------------------------------------------------
    // Median pipeline with descriptor delay line
    // ------------------------------------------------------------------
    logic         s1_v_reg, s2_v_reg, s3_v_reg;
    desc_t        s1_d_reg, s2_d_reg, s3_d_reg;
    logic [P-1:0] median;

    mf3_median #(
        .W (P)
    ) u_median (
        .clk    (clk),
        .window (window_reg),
        .median (median)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (cfg_restart)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= accept && src;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_d_reg <= desc_in;
        s2_d_reg <= s1_d_reg;
        s3_d_reg <= s2_d_reg;
    end

    // ------------------------------------------------------------------
    // Descriptor queue
    // ------------------------------------------------------------------
    entry_t           q_mem [QDEPTH];
    logic [QAW-1:0]   head_reg, tail_reg;
    logic [QCW-1:0]   q_count_reg;
    logic [QCW:0]     inflight;
    logic             push;
    logic             pop;
    entry_t           head;

    assign push = s3_v_reg;
    assign head = q_mem[head_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[tail_reg].d     <= s3_d_reg;
            q_mem[tail_reg].value <= median;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            q_count_reg <= '0;
        end
        else if (cfg_restart)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            q_count_reg <= '0;
        end
        else
        begin
            if (push)
                tail_reg <= (tail_reg == QAW'(QDEPTH - 1)) ? '0 : tail_reg + QAW'(1);
            if (pop)
                head_reg <= (head_reg == QAW'(QDEPTH - 1)) ? '0 : head_reg + QAW'(1);
            q_count_reg <= q_count_reg + QCW'(push) - QCW'(pop);
        end
    end

    // Hold input while the queue could not take every window in flight
    assign inflight = (QCW+1)'(q_count_reg) + (QCW+1)'(s1_v_reg) +
                      (QCW+1)'(s2_v_reg) + (QCW+1)'(s3_v_reg);
    assign pixels.ready = (inflight < (QCW+1)'(QDEPTH));

    // ------------------------------------------------------------------
    // Burst expander: walk the copy grid of the head entry
    // ------------------------------------------------------------------
    logic         started_reg;
    logic [1:0]   i_reg, j_reg;
    logic [3:0]   k_reg;
    logic [1:0]   first_i, first_j, cur_i, cur_j, nxt_i, nxt_j, row_i, col_j;
    logic [3:0]   cur_k;
    logic         nj_ok, ni_ok, has_next;
    logic         is9, last, hold;
    logic         exp_valid, load;
    logic         arm_reg;
    logic [QCW-1:0] rel_cnt_reg;
    logic         rel_inc, rel_dec;
    logic [RW-1:0] sel_row;
    logic [CW-1:0] sel_col;

    logic         out_v_reg;
    result_item_t out_reg;

    assign first_i = head.d.top  ? SUB_LOW : SUB_MID;
    assign first_j = head.d.left ? SUB_LOW : SUB_MID;
    assign cur_i   = started_reg ? i_reg : first_i;
    assign cur_j   = started_reg ? j_reg : first_j;
    assign cur_k   = started_reg ? k_reg : 4'd0;
    assign is9     = head.d.top && head.d.bottom && head.d.left && head.d.right;

    always_comb
    begin
        nj_ok = 1'b0;
        row_i = SUB_MID;
        col_j = SUB_MID;
        case (cur_j)
            SUB_LOW:  nj_ok = 1'b1;
            SUB_MID:
            begin
                nj_ok = head.d.right;
                col_j = SUB_HIGH;
            end
            default:  nj_ok = 1'b0;
        endcase
        case (cur_i)
            SUB_LOW:  ni_ok = 1'b1;
            SUB_MID:
            begin
                ni_ok = head.d.bottom;
                row_i = SUB_HIGH;
            end
            default:  ni_ok = 1'b0;
        endcase
    end

    assign has_next = nj_ok || ni_ok;
    assign nxt_i    = nj_ok ? cur_i : row_i;
    assign nxt_j    = nj_ok ? col_j : first_j;

    // The sixth result of a nine-copy burst closes its transfer group;
    // the rest wait for the next pixel transfer.
    assign last      = !has_next || (is9 && cur_k == 4'(MAX_BURST - 1));
    assign hold      = is9 && (cur_k == 4'(MAX_BURST)) && (rel_cnt_reg == '0);
    assign exp_valid = (q_count_reg != '0) && !hold;
    assign load      = exp_valid && (!out_v_reg || results.ready);
    assign pop       = load && !has_next;

    always_comb
    begin
        case (cur_i)
            SUB_LOW:  sel_row = '0;
            SUB_MID:  sel_row = head.d.ci;
            default:  sel_row = h_lastc;
        endcase
        case (cur_j)
            SUB_LOW:  sel_col = '0;
            SUB_MID:  sel_col = head.d.cj;
            default:  sel_col = w_lastc;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            i_reg       <= SUB_LOW;
            j_reg       <= SUB_LOW;
            k_reg       <= '0;
        end
        else if (cfg_restart)
        begin
            started_reg <= 1'b0;
            k_reg       <= '0;
        end
        else if (load)
        begin
            if (has_next)
            begin
                started_reg <= 1'b1;
                i_reg       <= nxt_i;
                j_reg       <= nxt_j;
                k_reg       <= cur_k + 4'd1;
            end
            else
            begin
                started_reg <= 1'b0;
                k_reg       <= '0;
            end
        end
    end

    // Release credit for the held tail of a nine-copy burst; one credit per
    // nine-copy entry still in flight at most, so the queue depth bounds it
    assign rel_inc = accept && arm_reg;
    assign rel_dec = load && is9 && (cur_k == 4'(MAX_BURST));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm_reg     <= 1'b0;
            rel_cnt_reg <= '0;
        end
        else if (cfg_restart)
        begin
            arm_reg     <= 1'b0;
            rel_cnt_reg <= '0;
        end
        else
        begin
            if (accept)
                arm_reg <= src_is9;
            rel_cnt_reg <= rel_cnt_reg + QCW'(rel_inc) - QCW'(rel_dec);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else
            out_v_reg <= load || (out_v_reg && !results.ready);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.out_row       <= POS_W'(sel_row);
            out_reg.out_col       <= POS_W'(sel_col);
            out_reg.out_value     <= VALUE_W'(head.value);
            out_reg.last_of_burst <= last;
        end
    end

    assign results.valid = out_v_reg;
    assign results.data  = out_reg;

`ifndef ASSERT_OFF
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight <= (QCW+1)'(QDEPTH))
        else $error("descriptor queue credit exceeded");

    a_restart_flush: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_restart |=> (q_count_reg == '0 && !s1_v_reg && !s2_v_reg && !s3_v_reg
                         && col_reg == '0 && row_reg == '0))
        else $error("frame restart left work in flight");

    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= w_lastc) && (row_reg <= h_lastc))
        else $error("frame position outside configured size");
`endif

endmodule
